// ----- sv/iis_pkg.sv -----
`default_nettype none

package iis_pkg;

  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 64;
  localparam int RSLOT_W    = 10;
  localparam int VALUE_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int OLEN_W     = 12;
  localparam int RTM_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_TYPE_MAX = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NARROW    = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    logic               mark;
    logic [VALUE_W-1:0] value;
  } slot_entry_t;

endpackage

`default_nettype wire

// ----- sv/iis_if.sv -----
`default_nettype none

interface iis_in_if import iis_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] index;
  logic               index_null;
  logic [RSLOT_W-1:0] read_slot;

  modport source (output valid, command, index, index_null, read_slot, input ready);
  modport sink   (input valid, command, index, index_null, read_slot, output ready);
endinterface

interface iis_out_if import iis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  slot_value;
  logic                slot_valid;
  logic [STATUS_W-1:0] status;

  modport source (output valid, slot_value, slot_valid, status, input ready);
  modport sink   (input valid, slot_value, slot_valid, status, output ready);
endinterface

interface iis_cfg_if import iis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- sv/iis_slot_ram.sv -----
`default_nettype none

module iis_slot_ram import iis_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire slot_entry_t   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output slot_entry_t        rdata_o
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/inverse_index_scatter_unit.sv -----
// Inverse index scatter.
// item_i carries commands: start (clear marks and counter), place (store the
// item's sequence number at the slot named by index), read (return one slot).
// result_o carries one beat per read: slot value, valid mark and status.
// cfg_i writes the slot count limit (index 0) and result_type_max (index 1).
// Start and place produce no beat. An accepted read registers a pending beat
// and a slot memory read; the beat is loaded into the output register once
// that register is free, and is offered on result_o from there.
// Reads sustain one per cycle while result_o keeps taking beats.
// The slot memory holds {mark, value}; one synchronous port pair sets the
// rate: one write (place or clear) and one read per cycle.
// After reset and after every start, a clearing sweep walks all SLOT_COUNT
// entries, one per cycle, resetting the marks; item_i is not ready during it.
// Configuration writes are taken at any time.
// When result_o stalls, one finished beat waits in the output register and
// one read waits behind it; item_i then drops ready until the output drains.
`default_nettype none

module inverse_index_scatter_unit import iis_pkg::*; #(
  parameter int              SLOT_COUNT = 1024,
  parameter longint unsigned MAX_ITEMS  = 65536
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iis_in_if.sink     item_i,
  iis_out_if.source  result_o,
  iis_cfg_if.sink    cfg_i
);

  localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > 16) ? CW : 16;

  logic [OLEN_W-1:0] olen_q, olen_d;
  logic [RTM_W-1:0]  rtm_q, rtm_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              sat_q, sat_d;
  logic              clr_q, clr_d;
  logic [SW-1:0]     clr_addr_q, clr_addr_d;
  logic              pend_q, pend_d;
  status_e           pend_status_q, pend_status_d;
  logic              out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic              out_mark_q, out_mark_d;
  status_e           out_status_q, out_status_d;

  cmd_e        cmd;
  logic        in_acc, move, rd_acc, start_acc;
  logic        ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  slot_entry_t ram_wdata, ram_rdata;
  logic [31:0] slot_ext;
  logic        idx_in_slots, idx_in_len, slot_in_mem, slot_in_len;
  status_e     rd_status;

  assign cmd       = cmd_e'(item_i.command);
  assign move      = pend_q & (~out_valid_q | result_o.ready);
  assign item_i.ready = ~clr_q & ~(pend_q & ~move);
  assign in_acc    = item_i.valid & item_i.ready;
  assign rd_acc    = in_acc & (cmd == CMD_READ);
  assign start_acc = in_acc & (cmd == CMD_START);
  assign cfg_i.ready = 1'b1;

  assign slot_ext     = 32'(item_i.read_slot);
  assign idx_in_slots = item_i.index < 64'(SLOT_COUNT);
  assign idx_in_len   = olen_q[OLEN_W-1] | (item_i.index < 64'(olen_q[OLEN_W-2:0]));
  assign slot_in_mem  = slot_ext < 32'(SLOT_COUNT);
  assign slot_in_len  = olen_q[OLEN_W-1] ? (CMPW'(item_i.read_slot) < CMPW'(cnt_q))
                                         : (CMPW'(item_i.read_slot) <
                                            CMPW'(olen_q[OLEN_W-2:0]));

  always_comb begin
    if (sat_q) begin
      rd_status = ST_SATURATED;
    end else if (CMPW'(cnt_q) > CMPW'(rtm_q)) begin
      rd_status = ST_NARROW;
    end else if (!slot_in_len || !slot_in_mem) begin
      rd_status = ST_BEYOND;
    end else begin
      rd_status = ST_OK;
    end
  end

  // item handling, counter and clearing sweep
  always_comb begin
    cnt_d      = cnt_q;
    sat_d      = sat_q;
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    ram_we     = 1'b0;
    ram_waddr  = item_i.index[SW-1:0];
    ram_wdata  = '{mark: 1'b1, value: VALUE_W'(cnt_q)};
    if (clr_q) begin
      ram_we     = 1'b1;
      ram_waddr  = clr_addr_q;
      ram_wdata  = '{mark: 1'b0, value: '0};
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == SW'(SLOT_COUNT - 1)) begin
        clr_d = 1'b0;
      end
    end else if (in_acc) begin
      unique case (cmd)
        CMD_START: begin
          cnt_d      = '0;
          sat_d      = 1'b0;
          clr_d      = 1'b1;
          clr_addr_d = '0;
        end
        CMD_PLACE: begin
          if (cnt_q == CW'(MAX_ITEMS)) begin
            sat_d = 1'b1;
          end else begin
            cnt_d  = cnt_q + 1'b1;
            ram_we = ~item_i.index_null & idx_in_slots & idx_in_len;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_re    = rd_acc;
  assign ram_raddr = slot_ext[SW-1:0];

  iis_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // read pipeline: pending beat, then output register
  always_comb begin
    pend_d        = rd_acc | (pend_q & ~move);
    pend_status_d = rd_acc ? rd_status : pend_status_q;
    out_valid_d   = move | (out_valid_q & ~result_o.ready);
    out_value_d   = out_value_q;
    out_mark_d    = out_mark_q;
    out_status_d  = out_status_q;
    if (move) begin
      out_status_d = pend_status_q;
      if (pend_status_q == ST_OK && ram_rdata.mark) begin
        out_mark_d  = 1'b1;
        out_value_d = ram_rdata.value;
      end else begin
        out_mark_d  = 1'b0;
        out_value_d = '0;
      end
    end
  end

  always_comb begin
    olen_d = olen_q;
    rtm_d  = rtm_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_OUT_LEN:         olen_d = cfg_i.wdata[OLEN_W-1:0];
        CFG_RESULT_TYPE_MAX: rtm_d  = cfg_i.wdata[RTM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olen_q      <= '1;
      rtm_q       <= '1;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      olen_q      <= olen_d;
      rtm_q       <= rtm_d;
      cnt_q       <= cnt_d;
      sat_q       <= sat_d;
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    out_value_q   <= out_value_d;
    out_mark_q    <= out_mark_d;
    out_status_q  <= out_status_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.slot_value = out_value_q;
  assign result_o.slot_valid = out_mark_q;
  assign result_o.status     = out_status_q;

  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !move |=> pend_q)
    else $error("pending read beat dropped");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("item counter beyond limit");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> clr_q && clr_addr_q == '0 && cnt_q == '0 && !sat_q)
    else $error("start did not launch clearing sweep");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK |-> !out_mark_q && out_value_q == '0)
    else $error("error beat carries slot data");

endmodule

`default_nettype wire
